>>> src/rv32i_instruction_decoder_unit_defines.svh
// Assertion macros used by the checker file of the RV32I decoder.
`ifndef RV32I_INSTRUCTION_DECODER_UNIT_DEFINES_SVH
`define RV32I_INSTRUCTION_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RVID_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rvid: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RVID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rvid: next-cycle check failed");

`endif

>>> src/rvid_pkg.sv
package rvid_pkg;

   // Major opcodes of the RV32I base set.
   localparam logic [6:0] OPC_OP     = 7'd51;
   localparam logic [6:0] OPC_LOAD   = 7'd3;
   localparam logic [6:0] OPC_OP_IMM = 7'd19;
   localparam logic [6:0] OPC_JALR   = 7'd103;
   localparam logic [6:0] OPC_SYSTEM = 7'd115;
   localparam logic [6:0] OPC_STORE  = 7'd35;
   localparam logic [6:0] OPC_BRANCH = 7'd99;
   localparam logic [6:0] OPC_LUI    = 7'd55;
   localparam logic [6:0] OPC_AUIPC  = 7'd23;
   localparam logic [6:0] OPC_JAL    = 7'd111;

   // funct3 codes of the ALU operations.
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // funct3 codes of loads and stores.
   localparam logic [2:0] F3_BYTE  = 3'd0;
   localparam logic [2:0] F3_HALF  = 3'd1;
   localparam logic [2:0] F3_WORD  = 3'd2;
   localparam logic [2:0] F3_BYTEU = 3'd4;
   localparam logic [2:0] F3_HALFU = 3'd5;

   // funct3 codes of branches.
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   // funct7 codes and the SYSTEM immediates.
   localparam logic [6:0]  F7_BASE    = 7'b0000000;
   localparam logic [6:0]  F7_ALT     = 7'b0100000;
   localparam logic [11:0] IMM_ECALL  = 12'd0;
   localparam logic [11:0] IMM_EBREAK = 12'd1;

   typedef enum logic [5:0] {
      MN_UNKNOWN = 6'd0,
      MN_ADD     = 6'd1,
      MN_SLL     = 6'd2,
      MN_SLT     = 6'd3,
      MN_SLTU    = 6'd4,
      MN_XOR     = 6'd5,
      MN_SRL     = 6'd6,
      MN_OR      = 6'd7,
      MN_AND     = 6'd8,
      MN_SUB     = 6'd9,
      MN_SRA     = 6'd10,
      MN_LB      = 6'd11,
      MN_LH      = 6'd12,
      MN_LW      = 6'd13,
      MN_LBU     = 6'd14,
      MN_LHU     = 6'd15,
      MN_ADDI    = 6'd16,
      MN_SLTI    = 6'd17,
      MN_SLTIU   = 6'd18,
      MN_XORI    = 6'd19,
      MN_ORI     = 6'd20,
      MN_ANDI    = 6'd21,
      MN_SLLI    = 6'd22,
      MN_SRLI    = 6'd23,
      MN_SRAI    = 6'd24,
      MN_JALR    = 6'd25,
      MN_ECALL   = 6'd26,
      MN_EBREAK  = 6'd27,
      MN_SB      = 6'd28,
      MN_SH      = 6'd29,
      MN_SW      = 6'd30,
      MN_BEQ     = 6'd31,
      MN_BNE     = 6'd32,
      MN_BLT     = 6'd33,
      MN_BGE     = 6'd34,
      MN_BLTU    = 6'd35,
      MN_BGEU    = 6'd36,
      MN_LUI     = 6'd37,
      MN_AUIPC   = 6'd38,
      MN_JAL     = 6'd39
   } mnemonic_type;

   typedef enum logic [2:0] {
      FMT_NONE = 3'd0,
      FMT_R    = 3'd1,
      FMT_I    = 3'd2,
      FMT_S    = 3'd3,
      FMT_B    = 3'd4,
      FMT_U    = 3'd5,
      FMT_J    = 3'd6
   } format_type;

endpackage

>>> src/rvid_if.sv
// Instruction word channel.
interface rvid_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_word;

   modport source (output valid, output instr_word, input ready);
   modport sink (input valid, input instr_word, output ready);
endinterface

// Decoded instruction channel.
interface rvid_rsp_if;
   import rvid_pkg::*;

   logic                valid;
   logic                ready;
   mnemonic_type        mnemonic;
   format_type          format;
   logic [4:0]          dest_reg;
   logic [4:0]          src1_reg;
   logic [4:0]          src2_reg;
   logic signed [20:0]  immediate;

   modport source (output valid, output mnemonic, output format, output dest_reg,
                   output src1_reg, output src2_reg, output immediate, input ready);
   modport sink (input valid, input mnemonic, input format, input dest_reg,
                 input src1_reg, input src2_reg, input immediate, output ready);
endinterface

>>> src/rv32i_instruction_decoder_unit.sv
// RV32I instruction decoder. Each instruction word taken on the req_if channel
// comes out on rsp_if as a mnemonic code, its operand format, the register
// indices that format uses (others read as zero) and the immediate, which is
// sign-extended for I, S, B and J formats and the raw 20-bit field for U.
// Words that are not a recognized RV32I instruction give mnemonic zero and all
// other fields zero. The block takes one word per clock cycle unless rsp_if
// stalls; a word passes from the input register through the single decode stage
// to the result register. When rsp_if stalls, the two stages fill before
// req_if.ready drops.
module rv32i_instruction_decoder_unit (
   input logic        clock,
   input logic        reset,
   rvid_req_if.sink   req_if,
   rvid_rsp_if.source rsp_if
);
   import rvid_pkg::*;

   logic               req_valid_ff;
   logic [31:0]        word_ff;
   logic               rsp_valid_ff;
   mnemonic_type       mnemonic_ff;
   format_type         format_ff;
   logic [4:0]         dest_reg_ff;
   logic [4:0]         src1_reg_ff;
   logic [4:0]         src2_reg_ff;
   logic signed [20:0] immediate_ff;

   mnemonic_type       mnemonic_in;
   format_type         format_in;
   logic [4:0]         dest_reg_in;
   logic [4:0]         src1_reg_in;
   logic [4:0]         src2_reg_in;
   logic signed [20:0] immediate_in;

   logic               stage2_ready;
   logic               stage1_ready;

   logic [6:0]         opc;
   logic [2:0]         f3;
   logic [6:0]         f7;
   logic [4:0]         rd;
   logic [4:0]         rs1;
   logic [4:0]         rs2;
   logic [11:0]        imm12;
   logic signed [20:0] imm_i;
   logic signed [20:0] imm_s;
   logic signed [20:0] imm_b;
   logic signed [20:0] imm_u;
   logic signed [20:0] imm_j;
   logic signed [20:0] imm_sys;
   mnemonic_type       mn;
   format_type         fmt;
   logic signed [20:0] imm;

   // Handshake: each stage moves when the stage after it is free or draining.
   assign stage2_ready = !rsp_valid_ff || rsp_if.ready;
   assign stage1_ready = !req_valid_ff || stage2_ready;
   assign req_if.ready = stage1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (stage1_ready) begin
            req_valid_ff <= req_if.valid;
         end
         if (stage2_ready) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   // Input register captures the word on each transfer.
   always_ff @(posedge clock) begin
      if (stage1_ready && req_if.valid) begin
         word_ff <= req_if.instr_word;
      end
   end

   // Instruction fields.
   assign opc   = word_ff[6:0];
   assign rd    = word_ff[11:7];
   assign f3    = word_ff[14:12];
   assign rs1   = word_ff[19:15];
   assign rs2   = word_ff[24:20];
   assign f7    = word_ff[31:25];
   assign imm12 = word_ff[31:20];

   // Immediates of every format, assembled in parallel.
   assign imm_i   = {{9{word_ff[31]}}, word_ff[31:20]};
   assign imm_s   = {{9{word_ff[31]}}, word_ff[31:25], word_ff[11:7]};
   assign imm_b   = {{8{word_ff[31]}}, word_ff[31], word_ff[7], word_ff[30:25],
                     word_ff[11:8], 1'b0};
   assign imm_u   = {1'b0, word_ff[31:12]};
   assign imm_j   = {word_ff[31], word_ff[19:12], word_ff[20], word_ff[30:21], 1'b0};
   assign imm_sys = {9'd0, imm12};

   // Mnemonic, format and immediate selection by opcode and function fields.
   always_comb begin
      mn  = MN_UNKNOWN;
      fmt = FMT_NONE;
      imm = '0;
      case (opc)
         OPC_OP: begin
            fmt = FMT_R;
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD:  mn = MN_ADD;
                  F3_SLL:  mn = MN_SLL;
                  F3_SLT:  mn = MN_SLT;
                  F3_SLTU: mn = MN_SLTU;
                  F3_XOR:  mn = MN_XOR;
                  F3_SR:   mn = MN_SRL;
                  F3_OR:   mn = MN_OR;
                  F3_AND:  mn = MN_AND;
                  default: mn = MN_UNKNOWN;
               endcase
            end else if (f7 == F7_ALT && f3 == F3_ADD) begin
               mn = MN_SUB;
            end else if (f7 == F7_ALT && f3 == F3_SR) begin
               mn = MN_SRA;
            end
         end
         OPC_LOAD: begin
            fmt = FMT_I;
            imm = imm_i;
            case (f3)
               F3_BYTE:  mn = MN_LB;
               F3_HALF:  mn = MN_LH;
               F3_WORD:  mn = MN_LW;
               F3_BYTEU: mn = MN_LBU;
               F3_HALFU: mn = MN_LHU;
               default:  mn = MN_UNKNOWN;
            endcase
         end
         OPC_OP_IMM: begin
            fmt = FMT_I;
            imm = imm_i;
            case (f3)
               F3_ADD:  mn = MN_ADDI;
               F3_SLT:  mn = MN_SLTI;
               F3_SLTU: mn = MN_SLTIU;
               F3_XOR:  mn = MN_XORI;
               F3_OR:   mn = MN_ORI;
               F3_AND:  mn = MN_ANDI;
               F3_SLL:  mn = (f7 == F7_BASE) ? MN_SLLI : MN_UNKNOWN;
               F3_SR: begin
                  if (f7 == F7_BASE) begin
                     mn = MN_SRLI;
                  end else if (f7 == F7_ALT) begin
                     mn = MN_SRAI;
                  end else begin
                     mn = MN_UNKNOWN;
                  end
               end
               default: mn = MN_UNKNOWN;
            endcase
         end
         OPC_JALR: begin
            fmt = FMT_I;
            imm = imm_i;
            if (f3 == F3_ADD) begin
               mn = MN_JALR;
            end
         end
         OPC_SYSTEM: begin
            fmt = FMT_I;
            imm = imm_sys;
            if (f3 == F3_ADD && rs1 == 5'd0 && rd == 5'd0) begin
               if (imm12 == IMM_ECALL) begin
                  mn = MN_ECALL;
               end else if (imm12 == IMM_EBREAK) begin
                  mn = MN_EBREAK;
               end
            end
         end
         OPC_STORE: begin
            fmt = FMT_S;
            imm = imm_s;
            case (f3)
               F3_BYTE: mn = MN_SB;
               F3_HALF: mn = MN_SH;
               F3_WORD: mn = MN_SW;
               default: mn = MN_UNKNOWN;
            endcase
         end
         OPC_BRANCH: begin
            fmt = FMT_B;
            imm = imm_b;
            case (f3)
               F3_BEQ:  mn = MN_BEQ;
               F3_BNE:  mn = MN_BNE;
               F3_BLT:  mn = MN_BLT;
               F3_BGE:  mn = MN_BGE;
               F3_BLTU: mn = MN_BLTU;
               F3_BGEU: mn = MN_BGEU;
               default: mn = MN_UNKNOWN;
            endcase
         end
         OPC_LUI: begin
            fmt = FMT_U;
            imm = imm_u;
            mn  = MN_LUI;
         end
         OPC_AUIPC: begin
            fmt = FMT_U;
            imm = imm_u;
            mn  = MN_AUIPC;
         end
         OPC_JAL: begin
            fmt = FMT_J;
            imm = imm_j;
            mn  = MN_JAL;
         end
         default: begin
            mn = MN_UNKNOWN;
         end
      endcase
   end

   // Zero out whatever the decoded format does not use.
   always_comb begin
      mnemonic_in  = mn;
      format_in    = fmt;
      immediate_in = imm;
      if (mn == MN_UNKNOWN) begin
         format_in    = FMT_NONE;
         immediate_in = '0;
      end
      dest_reg_in = (format_in == FMT_R || format_in == FMT_I ||
                     format_in == FMT_U || format_in == FMT_J) ? rd : 5'd0;
      src1_reg_in = (format_in == FMT_R || format_in == FMT_I ||
                     format_in == FMT_S || format_in == FMT_B) ? rs1 : 5'd0;
      src2_reg_in = (format_in == FMT_R || format_in == FMT_S ||
                     format_in == FMT_B) ? rs2 : 5'd0;
   end

   // Result register, loaded when a decoded word moves forward.
   always_ff @(posedge clock) begin
      if (stage2_ready && req_valid_ff) begin
         mnemonic_ff  <= mnemonic_in;
         format_ff    <= format_in;
         dest_reg_ff  <= dest_reg_in;
         src1_reg_ff  <= src1_reg_in;
         src2_reg_ff  <= src2_reg_in;
         immediate_ff <= immediate_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.mnemonic  = mnemonic_ff;
   assign rsp_if.format    = format_ff;
   assign rsp_if.dest_reg  = dest_reg_ff;
   assign rsp_if.src1_reg  = src1_reg_ff;
   assign rsp_if.src2_reg  = src2_reg_ff;
   assign rsp_if.immediate = immediate_ff;

endmodule

>>> src/rvid_checker.sv
`include "rv32i_instruction_decoder_unit_defines.svh"

// Port-level checks on the decoded result channel.
module rvid_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rvid_pkg::mnemonic_type mnemonic,
   input rvid_pkg::format_type  format,
   input logic [4:0]            dest_reg,
   input logic [4:0]            src1_reg,
   input logic [4:0]            src2_reg,
   input logic signed [20:0]    immediate
);
   import rvid_pkg::*;

   // An unknown word carries no format, registers or immediate.
   `RVID_ASSERT_SAME(a_unknown_clear, clock, reset, rsp_valid && mnemonic == MN_UNKNOWN, format == FMT_NONE && dest_reg == 5'd0 && src1_reg == 5'd0 && src2_reg == 5'd0 && immediate == 21'sd0)

   // R-format results are register ALU operations with no immediate.
   `RVID_ASSERT_SAME(a_rtype_shape, clock, reset, rsp_valid && format == FMT_R, mnemonic >= MN_ADD && mnemonic <= MN_SRA && immediate == 21'sd0)

   // U and J formats read no source register; S and B write none.
   `RVID_ASSERT_SAME(a_uj_no_src, clock, reset, rsp_valid && (format == FMT_U || format == FMT_J), src1_reg == 5'd0 && src2_reg == 5'd0)
   `RVID_ASSERT_SAME(a_sb_no_dest, clock, reset, rsp_valid && (format == FMT_S || format == FMT_B), dest_reg == 5'd0)

   // A stalled result stays offered, with its mnemonic, format, immediate and destination unchanged.
   `RVID_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(mnemonic) && $stable(format) && $stable(immediate) && $stable(dest_reg))

endmodule

bind rv32i_instruction_decoder_unit rvid_checker u_rvid_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .mnemonic  (rsp_if.mnemonic),
   .format    (rsp_if.format),
   .dest_reg  (rsp_if.dest_reg),
   .src1_reg  (rsp_if.src1_reg),
   .src2_reg  (rsp_if.src2_reg),
   .immediate (rsp_if.immediate)
);

>>> tb/rv32i_instruction_decoder_unit_tb.sv
module rv32i_instruction_decoder_unit_tb;
   import rvid_pkg::*;

   // funct3 that JALR and the SYSTEM privileged words require.
   localparam logic [2:0] F3_JALR = 3'd0;
   localparam logic [2:0] F3_PRIV = 3'd0;

   localparam int unsigned RANDOM_WORDS = 1825;
   localparam int unsigned DRAIN_CYCLES = 8;

   // One decoded instruction, laid out as the result channel carries it.
   typedef struct {
      mnemonic_type       mnemonic;
      format_type         format;
      logic [4:0]         dest_reg;
      logic [4:0]         src1_reg;
      logic [4:0]         src2_reg;
      logic signed [20:0] immediate;
   } decoded_type;

   // An instruction word together with the decode it must produce.
   typedef struct {
      logic [31:0] word;
      decoded_type outcome;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rvid_req_if req_ch ();
   rvid_rsp_if rsp_ch ();

   rv32i_instruction_decoder_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   decoded_type pending_decodes[$];
   int unsigned failure_count = 0;
   int unsigned burst_left = 0;
   logic [7:0]  stall_phase = 8'd0;

   always #1 clock = ~clock;

   // Decode one word the way the RV32I base ISA defines it.
   function automatic decoded_type decode_instruction(input logic [31:0] w);
      decoded_type d;
      logic [2:0]  f3;
      logic [6:0]  f7;
      f3 = w[14:12];
      f7 = w[31:25];
      d.mnemonic  = MN_UNKNOWN;
      d.format    = FMT_NONE;
      d.dest_reg  = w[11:7];
      d.src1_reg  = w[19:15];
      d.src2_reg  = w[24:20];
      d.immediate = '0;
      case (w[6:0])
         OPC_OP: begin
            d.format = FMT_R;
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD:  d.mnemonic = MN_ADD;
                  F3_SLL:  d.mnemonic = MN_SLL;
                  F3_SLT:  d.mnemonic = MN_SLT;
                  F3_SLTU: d.mnemonic = MN_SLTU;
                  F3_XOR:  d.mnemonic = MN_XOR;
                  F3_SR:   d.mnemonic = MN_SRL;
                  F3_OR:   d.mnemonic = MN_OR;
                  default: d.mnemonic = MN_AND;
               endcase
            end else if (f7 == F7_ALT && f3 == F3_ADD) begin
               d.mnemonic = MN_SUB;
            end else if (f7 == F7_ALT && f3 == F3_SR) begin
               d.mnemonic = MN_SRA;
            end
         end
         OPC_LOAD: begin
            d.format = FMT_I;
            d.immediate = {{9{w[31]}}, w[31:20]};
            case (f3)
               F3_BYTE:  d.mnemonic = MN_LB;
               F3_HALF:  d.mnemonic = MN_LH;
               F3_WORD:  d.mnemonic = MN_LW;
               F3_BYTEU: d.mnemonic = MN_LBU;
               F3_HALFU: d.mnemonic = MN_LHU;
               default:  d.mnemonic = MN_UNKNOWN;
            endcase
         end
         OPC_OP_IMM: begin
            d.format = FMT_I;
            d.immediate = {{9{w[31]}}, w[31:20]};
            case (f3)
               F3_ADD:  d.mnemonic = MN_ADDI;
               F3_SLT:  d.mnemonic = MN_SLTI;
               F3_SLTU: d.mnemonic = MN_SLTIU;
               F3_XOR:  d.mnemonic = MN_XORI;
               F3_OR:   d.mnemonic = MN_ORI;
               F3_AND:  d.mnemonic = MN_ANDI;
               F3_SLL:  d.mnemonic = (f7 == F7_BASE) ? MN_SLLI : MN_UNKNOWN;
               default: begin
                  if (f7 == F7_BASE) d.mnemonic = MN_SRLI;
                  else if (f7 == F7_ALT) d.mnemonic = MN_SRAI;
               end
            endcase
         end
         OPC_JALR: begin
            d.format = FMT_I;
            d.immediate = {{9{w[31]}}, w[31:20]};
            if (f3 == F3_JALR) d.mnemonic = MN_JALR;
         end
         OPC_SYSTEM: begin
            // Only the exact ECALL and EBREAK encodings are recognized.
            d.format = FMT_I;
            d.immediate = {9'd0, w[31:20]};
            if (f3 == F3_PRIV && w[19:15] == 5'd0 && w[11:7] == 5'd0) begin
               if (w[31:20] == IMM_ECALL) d.mnemonic = MN_ECALL;
               else if (w[31:20] == IMM_EBREAK) d.mnemonic = MN_EBREAK;
            end
         end
         OPC_STORE: begin
            d.format = FMT_S;
            d.immediate = {{9{w[31]}}, w[31:25], w[11:7]};
            case (f3)
               F3_BYTE: d.mnemonic = MN_SB;
               F3_HALF: d.mnemonic = MN_SH;
               F3_WORD: d.mnemonic = MN_SW;
               default: d.mnemonic = MN_UNKNOWN;
            endcase
         end
         OPC_BRANCH: begin
            d.format = FMT_B;
            d.immediate = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            case (f3)
               F3_BEQ:  d.mnemonic = MN_BEQ;
               F3_BNE:  d.mnemonic = MN_BNE;
               F3_BLT:  d.mnemonic = MN_BLT;
               F3_BGE:  d.mnemonic = MN_BGE;
               F3_BLTU: d.mnemonic = MN_BLTU;
               F3_BGEU: d.mnemonic = MN_BGEU;
               default: d.mnemonic = MN_UNKNOWN;
            endcase
         end
         OPC_LUI: begin
            d.format = FMT_U;
            d.mnemonic = MN_LUI;
            d.immediate = {1'b0, w[31:12]};
         end
         OPC_AUIPC: begin
            d.format = FMT_U;
            d.mnemonic = MN_AUIPC;
            d.immediate = {1'b0, w[31:12]};
         end
         OPC_JAL: begin
            d.format = FMT_J;
            d.mnemonic = MN_JAL;
            d.immediate = {w[31], w[19:12], w[20], w[30:21], 1'b0};
         end
         default: d.mnemonic = MN_UNKNOWN;
      endcase

      // Unknown words carry nothing; unused register fields read as zero.
      if (d.mnemonic == MN_UNKNOWN) begin
         d.format = FMT_NONE;
         d.immediate = '0;
      end
      if (d.format inside {FMT_NONE, FMT_S, FMT_B}) d.dest_reg = '0;
      if (d.format inside {FMT_NONE, FMT_U, FMT_J}) d.src1_reg = '0;
      if (!(d.format inside {FMT_R, FMT_S, FMT_B})) d.src2_reg = '0;
      return d;
   endfunction

   // A row whose decode comes from the predictor.
   function automatic vector_type predicted(input logic [31:0] word);
      vector_type v;
      v.word = word;
      v.outcome = decode_instruction(word);
      return v;
   endfunction

   // A row whose decode is written out by hand.
   function automatic vector_type checked(input logic [31:0] word, input mnemonic_type mn,
                                          input format_type fmt, input logic [4:0] rd,
                                          input logic [4:0] rs1, input logic [4:0] rs2,
                                          input logic signed [20:0] imm);
      vector_type v;
      v.word = word;
      v.outcome.mnemonic  = mn;
      v.outcome.format    = fmt;
      v.outcome.dest_reg  = rd;
      v.outcome.src1_reg  = rs1;
      v.outcome.src2_reg  = rs2;
      v.outcome.immediate = imm;
      return v;
   endfunction

   // funct7 mostly legal for R-type and shifts, sometimes arbitrary.
   function automatic logic [6:0] likely_funct7();
      case ($urandom_range(0, 7))
         0:       return 7'($urandom_range(0, 127));
         1, 2, 3: return F7_BASE;
         default: return F7_ALT;
      endcase
   endfunction

   // Mostly well-formed instructions with random operands, plus raw noise.
   function automatic logic [31:0] random_instruction();
      logic [31:0] w;
      int unsigned bit_pos;
      w = $urandom();
      case ($urandom_range(0, 11))
         0: begin
            w[6:0] = OPC_OP;
            w[31:25] = likely_funct7();
         end
         1: w[6:0] = OPC_LOAD;
         2: begin
            w[6:0] = OPC_OP_IMM;
            if (w[14:12] == F3_SLL || w[14:12] == F3_SR) w[31:25] = likely_funct7();
         end
         3: begin
            w[6:0] = OPC_JALR;
            if ($urandom_range(0, 3) != 0) w[14:12] = F3_JALR;
         end
         4: begin
            // Exact ECALL/EBREAK, sometimes with one bit disturbed.
            w[6:0] = OPC_SYSTEM;
            if ($urandom_range(0, 3) != 0) begin
               w[31:20] = $urandom_range(0, 1) ? IMM_EBREAK : IMM_ECALL;
               w[19:7] = '0;
               if ($urandom_range(0, 2) == 0) begin
                  bit_pos = $urandom_range(7, 31);
                  w[bit_pos] = ~w[bit_pos];
               end
            end
         end
         5: w[6:0] = OPC_STORE;
         6: w[6:0] = OPC_BRANCH;
         7: w[6:0] = OPC_LUI;
         8: w[6:0] = OPC_AUIPC;
         9: w[6:0] = OPC_JAL;
         default: ;
      endcase
      return w;
   endfunction

   // Present one word, idling between bursts, and record its decode on transfer.
   task automatic send_instruction(input vector_type row);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 5);
         req_ch.valid <= 1'b0;
         req_ch.instr_word <= $urandom();
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.instr_word <= row.word;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_decodes.push_back(row.outcome);
   endtask

   task automatic report_mismatch(input string field, input logic signed [31:0] want,
                                  input logic signed [31:0] got);
      $error("%s: expected %0d, got %0d", field, want, got);
      failure_count++;
   endtask

   // Compare a transferred result with the oldest outstanding decode.
   task automatic check_result();
      decoded_type want;
      if (pending_decodes.size() == 0) begin
         $error("decoded result with no instruction outstanding");
         failure_count++;
      end else begin
         want = pending_decodes.pop_front();
         if (rsp_ch.mnemonic !== want.mnemonic)
            report_mismatch("mnemonic", want.mnemonic, rsp_ch.mnemonic);
         if (rsp_ch.format !== want.format)
            report_mismatch("format", want.format, rsp_ch.format);
         if (rsp_ch.dest_reg !== want.dest_reg)
            report_mismatch("dest_reg", want.dest_reg, rsp_ch.dest_reg);
         if (rsp_ch.src1_reg !== want.src1_reg)
            report_mismatch("src1_reg", want.src1_reg, rsp_ch.src1_reg);
         if (rsp_ch.src2_reg !== want.src2_reg)
            report_mismatch("src2_reg", want.src2_reg, rsp_ch.src2_reg);
         if (rsp_ch.immediate !== want.immediate)
            report_mismatch("immediate", want.immediate, rsp_ch.immediate);
      end
   endtask

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_result();
   end

   // Receiver backpressure: the mode is chosen by the top two bits of stall_phase.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 8'd1;
      case (stall_phase[7:6])
         2'd0:    rsp_ch.ready <= 1'b1;
         2'd1:    rsp_ch.ready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_ch.ready <= (stall_phase[1:0] == 2'd0);
         default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // Stimulus and end of test.
   initial begin
      vector_type directed_rows[$];
      req_ch.valid <= 1'b0;
      req_ch.instr_word <= '0;
      directed_rows = '{
         checked(32'h0000_0000, MN_UNKNOWN, FMT_NONE, 5'd0, 5'd0, 5'd0, 21'sd0),
         checked(32'hFFFF_FFFF, MN_UNKNOWN, FMT_NONE, 5'd0, 5'd0, 5'd0, 21'sd0),
         checked(32'h0000_0033, MN_ADD, FMT_R, 5'd0, 5'd0, 5'd0, 21'sd0),
         checked(32'h41FF_8FB3, MN_SUB, FMT_R, 5'd31, 5'd31, 5'd31, 21'sd0),
         predicted(32'h4000_5033),
         checked(32'h0200_0033, MN_UNKNOWN, FMT_NONE, 5'd0, 5'd0, 5'd0, 21'sd0),
         checked(32'hFFF0_0093, MN_ADDI, FMT_I, 5'd1, 5'd0, 5'd0, -21'sd1),
         predicted(32'h7FF0_2003),
         checked(32'h0000_3003, MN_UNKNOWN, FMT_NONE, 5'd0, 5'd0, 5'd0, 21'sd0),
         checked(32'h0200_1013, MN_UNKNOWN, FMT_NONE, 5'd0, 5'd0, 5'd0, 21'sd0),
         predicted(32'h41F2_D293),
         predicted(32'h0000_80E7),
         checked(32'h0000_1067, MN_UNKNOWN, FMT_NONE, 5'd0, 5'd0, 5'd0, 21'sd0),
         checked(32'h0000_0073, MN_ECALL, FMT_I, 5'd0, 5'd0, 5'd0, 21'sd0),
         checked(32'h0010_0073, MN_EBREAK, FMT_I, 5'd0, 5'd0, 5'd0, 21'sd1),
         checked(32'h0000_00F3, MN_UNKNOWN, FMT_NONE, 5'd0, 5'd0, 5'd0, 21'sd0),
         checked(32'h0020_0073, MN_UNKNOWN, FMT_NONE, 5'd0, 5'd0, 5'd0, 21'sd0),
         predicted(32'h8000_0023),
         checked(32'h0000_3023, MN_UNKNOWN, FMT_NONE, 5'd0, 5'd0, 5'd0, 21'sd0),
         predicted(32'h8000_0063),
         predicted(32'hFFFF_FFE3),
         checked(32'h0000_2063, MN_UNKNOWN, FMT_NONE, 5'd0, 5'd0, 5'd0, 21'sd0),
         checked(32'hFFFF_F037, MN_LUI, FMT_U, 5'd0, 5'd0, 5'd0, 21'sd1048575),
         predicted(32'h8000_006F),
         predicted(32'h7FFF_F0EF)
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_instruction(directed_rows[i]);
      repeat (RANDOM_WORDS) send_instruction(predicted(random_instruction()));
      req_ch.valid <= 1'b0;

      // Let every outstanding decode arrive, then watch for stray results.
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failure_count == 0) begin
         $display("rv32i_instruction_decoder_unit regression: pass");
      end else begin
         $display("rv32i_instruction_decoder_unit regression: fail");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #1000000;
      $display("rv32i_instruction_decoder_unit regression: fail");
      $finish;
   end

endmodule
